[rtl/core/g4_fax_line_encoder_unit_assert.svh]
// Assertion macros for the Group 4 line encoder
`ifndef G4_FAX_LINE_ENCODER_UNIT_ASSERT_SVH
`define G4_FAX_LINE_ENCODER_UNIT_ASSERT_SVH

// cons must hold in every cycle where ante holds
`define G4_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("g4 encoder check failed");

// cond must hold in every cycle out of reset
`define G4_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("g4 encoder invariant failed");

`endif

[rtl/core/g4fle_pkg.sv]
// Shared types, constants and code tables for the Group 4 line encoder
package g4fle_pkg;

    localparam int G4FLE_MAX_WIDTH = 4096;
    localparam logic [12:0] G4FLE_WIDTH_RESET = 13'd1728;
    localparam int G4FLE_CODE_W = 32;
    localparam int G4FLE_LEN_W = 5;

    typedef struct packed {
        logic [12:0] code;
        logic [3:0]  len;
    } vlc_t;

    typedef struct packed {
        logic                    valid;
        logic [G4FLE_CODE_W-1:0] code;
        logic [G4FLE_LEN_W-1:0]  len;
        logic                    final_job;
    } pk_job_t;

    typedef struct packed {
        logic       busy;
        logic [2:0] count;
    } pk_stat_t;

    localparam logic [12:0] WTERM_C [64] = '{
        'h35,'h07,'h07,'h08,'h0B,'h0C,'h0E,'h0F,
        'h13,'h14,'h07,'h08,'h08,'h03,'h34,'h35,
        'h2A,'h2B,'h27,'h0C,'h08,'h17,'h03,'h04,
        'h28,'h2B,'h13,'h24,'h18,'h02,'h03,'h1A,
        'h1B,'h12,'h13,'h14,'h15,'h16,'h17,'h28,
        'h29,'h2A,'h2B,'h2C,'h2D,'h04,'h05,'h0A,
        'h0B,'h52,'h53,'h54,'h55,'h24,'h25,'h58,
        'h59,'h5A,'h5B,'h4A,'h4B,'h32,'h33,'h34};
    localparam logic [3:0] WTERM_N [64] = '{
        4'd8,4'd6,4'd4,4'd4,4'd4,4'd4,4'd4,4'd4,
        4'd5,4'd5,4'd5,4'd5,4'd6,4'd6,4'd6,4'd6,
        4'd6,4'd6,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,
        4'd7,4'd7,4'd7,4'd7,4'd7,4'd8,4'd8,4'd8,
        4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,
        4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,
        4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,
        4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8};
    localparam logic [12:0] BTERM_C [64] = '{
        'h37,'h2,'h3,'h2,'h3,'h3,'h2,'h3,
        'h5,'h4,'h4,'h5,'h7,'h4,'h7,'h18,
        'h17,'h18,'h08,'h67,'h68,'h6C,'h37,'h28,
        'h17,'h18,'hCA,'hCB,'hCC,'hCD,'h68,'h69,
        'h6A,'h6B,'hD2,'hD3,'hD4,'hD5,'hD6,'hD7,
        'h6C,'h6D,'hDA,'hDB,'h54,'h55,'h56,'h57,
        'h64,'h65,'h52,'h53,'h24,'h37,'h38,'h27,
        'h28,'h58,'h59,'h2B,'h2C,'h5A,'h66,'h67};
    localparam logic [3:0] BTERM_N [64] = '{
        4'd10,4'd3,4'd2,4'd2,4'd3,4'd4,4'd4,4'd5,
        4'd6,4'd6,4'd7,4'd7,4'd7,4'd8,4'd8,4'd9,
        4'd10,4'd10,4'd10,4'd11,4'd11,4'd11,4'd11,4'd11,
        4'd11,4'd11,4'd12,4'd12,4'd12,4'd12,4'd12,4'd12,
        4'd12,4'd12,4'd12,4'd12,4'd12,4'd12,4'd12,4'd12,
        4'd12,4'd12,4'd12,4'd12,4'd12,4'd12,4'd12,4'd12,
        4'd12,4'd12,4'd12,4'd12,4'd12,4'd12,4'd12,4'd12,
        4'd12,4'd12,4'd12,4'd12,4'd12,4'd12,4'd12,4'd12};
    localparam logic [12:0] WMAKE_C [27] = '{
        'h1B,'h12,'h17,'h37,'h36,'h37,'h64,'h65,
        'h68,'h67,'hCC,'hCD,'hD2,'hD3,'hD4,'hD5,
        'hD6,'hD7,'hD8,'hD9,'hDA,'hDB,'h98,'h99,
        'h9A,'h18,'h9B};
    localparam logic [3:0] WMAKE_N [27] = '{
        4'd5,4'd5,4'd6,4'd7,4'd8,4'd8,4'd8,4'd8,
        4'd8,4'd8,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,
        4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,
        4'd9,4'd6,4'd9};
    localparam logic [12:0] BMAKE_C [27] = '{
        'h0F,'hC8,'hC9,'h5B,'h33,'h34,'h35,'h6C,
        'h6D,'h4A,'h4B,'h4C,'h4D,'h72,'h73,'h74,
        'h75,'h76,'h77,'h52,'h53,'h54,'h55,'h5A,
        'h5B,'h64,'h65};
    localparam logic [3:0] BMAKE_N [27] = '{
        4'd10,4'd12,4'd12,4'd12,4'd12,4'd12,4'd12,4'd13,
        4'd13,4'd13,4'd13,4'd13,4'd13,4'd13,4'd13,4'd13,
        4'd13,4'd13,4'd13,4'd13,4'd13,4'd13,4'd13,4'd13,
        4'd13,4'd13,4'd13};
    localparam logic [12:0] XMAKE_C [13] = '{
        'h08,'h0C,'h0D,'h12,'h13,'h14,'h15,'h16,'h17,'h1C,'h1D,'h1E,'h1F};
    localparam logic [3:0] XMAKE_N [13] = '{
        4'd11,4'd11,4'd11,4'd12,4'd12,4'd12,4'd12,4'd12,4'd12,4'd12,4'd12,4'd12,4'd12};
    localparam logic [12:0] VERT_C [7] = '{'h02,'h02,'h2,'h1,'h3,'h03,'h03};
    localparam logic [3:0]  VERT_N [7] = '{4'd7,4'd6,4'd3,4'd1,4'd3,4'd6,4'd7};

    function automatic vlc_t term_vlc(input logic [5:0] r, input logic black);
        vlc_t v;
        if (black) v = '{BTERM_C[r], BTERM_N[r]};
        else       v = '{WTERM_C[r], WTERM_N[r]};
        return v;
    endfunction

    // k counts units of 64 pels, 1..40
    function automatic vlc_t makeup_vlc(input logic [5:0] k, input logic black);
        logic [5:0] ix;
        logic [5:0] iy;
        vlc_t       v;
        ix = k - 6'd28;
        iy = k - 6'd1;
        if (k >= 6'd28)  v = '{XMAKE_C[ix[3:0]], XMAKE_N[ix[3:0]]};
        else if (black)  v = '{BMAKE_C[iy[4:0]], BMAKE_N[iy[4:0]]};
        else             v = '{WMAKE_C[iy[4:0]], WMAKE_N[iy[4:0]]};
        return v;
    endfunction

    function automatic vlc_t vert_vlc(input logic [2:0] idx);
        vlc_t v;
        v = '{VERT_C[idx], VERT_N[idx]};
        return v;
    endfunction

endpackage

[rtl/core/g4_fax_line_encoder_unit.sv]
// Group 4 (T.6) bilevel line encoder: sequencer, line stores and code packer
//
// Input channel s_valid/s_ready carries one pel (s_op = 0, s_pixel 1 = black)
// or an end of page (s_op = 1). Output channel m_valid/m_ready carries packed
// code bytes, first code bit in the MSB, m_last set on the final byte of a page.
// cfg_wr_en/cfg_wr_data set the line width, latched at the first pel of a line.
// Each pel is accepted, then runs the step, reference, coding read and decide
// states as needed. Each element scanned on the reference or coding line store
// takes a read and a check state (single read port, registered data); search
// state is kept between pels, so each line element is revisited only a few times.
// Code bits leave the packer one per cycle in parallel with the search; a new
// code waits only while the packer still holds the previous one.
// End of page: EOFB plus zero padding, then page state clears.
// Reset: reference line reads all white, no clearing pass; width resets to 1728.
// A stalled receiver holds the packer at the next full byte; the sequencer then
// waits at its next code and s_ready stays low.
`include "g4_fax_line_encoder_unit_assert.svh"
module g4_fax_line_encoder_unit
    import g4fle_pkg::*;
#(
    parameter int MAX_WIDTH = G4FLE_MAX_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic        s_pixel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data
);

    localparam int PW = $clog2(MAX_WIDTH + 3);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = (PW > 7) ? PW : 7;
    localparam logic [13:0] MAXW14 = 14'(MAX_WIDTH);

    localparam logic [1:0] RPH_Y  = 2'd0;
    localparam logic [1:0] RPH_B1 = 2'd1;
    localparam logic [1:0] RPH_B2 = 2'd2;

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b00000000001,
        ST_STEP      = 11'b00000000010,
        ST_REF_RD    = 11'b00000000100,
        ST_REF_CHK   = 11'b00000001000,
        ST_COD_RD    = 11'b00000010000,
        ST_COD_CHK   = 11'b00000100000,
        ST_DECIDE    = 11'b00001000000,
        ST_HMODE     = 11'b00010000000,
        ST_RUN       = 11'b00100000000,
        ST_EOF_ISSUE = 11'b01000000000,
        ST_EOF_WAIT  = 11'b10000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [12:0]   lw_reg;
    logic [PW-1:0] len_reg, len_next;
    logic [PW-1:0] ref_len_reg, ref_len_next;
    logic          sel_reg, sel_next;
    logic [PW-1:0] p_reg, p_next;
    logic [PW-1:0] a0_reg, a0_next;
    logic          c_reg, c_next;
    logic          bvalid_reg, bvalid_next;
    logic          a1f_reg, a1f_next;
    logic          a2f_reg, a2f_next;
    logic          cphase_reg, cphase_next;
    logic [PW-1:0] cx_reg, cx_next;
    logic [PW-1:0] x_reg, x_next;
    logic [1:0]    rph_reg, rph_next;
    logic [PW-1:0] b1_reg, b1_next;
    logic [PW-1:0] b2_reg, b2_next;
    logic [PW-1:0] a1_reg, a1_next;
    logic [PW-1:0] a2_reg, a2_next;
    logic [RW-1:0] r_reg, r_next;
    logic          rcol_reg, rcol_next;
    logic          rsel_reg, rsel_next;

    pk_job_t       job;
    pk_stat_t      pk_stat;

    logic [13:0]   lw_ext;
    logic [PW-1:0] l_new, l_cur, p_plus, p_inc, wpos_m1, rpos, rpos_m1;
    logic          wr_en, we0, we1, rd0, rd1;
    logic          ref_bit, cod_bit, ref_in, refp, ref_target, ref_stop;
    logic          cod_col, cod_hit;
    logic [PW-1:0] found_pos, len_p1;
    logic [PW:0]   a1_w, b1_w;
    logic          is_vert;
    logic [PW-1:0] vdiff, run1, run2;
    logic [RW-1:0] rk;
    logic [5:0]    k6;
    logic [2:0]    pad;
    vlc_t          v_vert, v_make, v_term;

    // line width clamp
    assign lw_ext = {1'b0, lw_reg};
    assign l_new  = (lw_reg == '0) ? PW'(1) :
                    (lw_ext > MAXW14) ? PW'(MAX_WIDTH) : PW'(lw_reg);
    assign l_cur  = (p_reg == '0) ? l_new : len_reg;
    assign p_plus = p_reg + PW'(1);
    assign p_inc  = (p_plus > l_cur) ? l_cur : p_plus;
    assign wpos_m1 = p_inc - PW'(1);
    assign rpos    = (state_reg == ST_COD_RD) ? cx_reg : x_reg;
    assign rpos_m1 = rpos - PW'(1);

    assign we0 = wr_en && !sel_reg;
    assign we1 = wr_en && sel_reg;

    g4fle_ram #(.DEPTH(MAX_WIDTH)) u_store0 (
        .aclk  (aclk),
        .we    (we0),
        .waddr (wpos_m1[AW-1:0]),
        .wdata (s_pixel),
        .raddr (rpos_m1[AW-1:0]),
        .rdata (rd0)
    );

    g4fle_ram #(.DEPTH(MAX_WIDTH)) u_store1 (
        .aclk  (aclk),
        .we    (we1),
        .waddr (wpos_m1[AW-1:0]),
        .wdata (s_pixel),
        .raddr (rpos_m1[AW-1:0]),
        .rdata (rd1)
    );

    g4fle_packer u_packer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job        (job),
        .stat       (pk_stat),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

    // coding line lives in store[sel], reference in the other one
    assign ref_bit    = sel_reg ? rd0 : rd1;
    assign cod_bit    = sel_reg ? rd1 : rd0;
    assign ref_in     = (x_reg != '0) && (x_reg <= ref_len_reg);
    assign refp       = ref_in && ref_bit;
    assign ref_target = (rph_reg == RPH_B1) ? !c_reg : c_reg;
    assign ref_stop   = ((state_reg == ST_REF_RD) && (x_reg > len_reg)) ||
                        ((state_reg == ST_REF_CHK) && (refp == ref_target));

    assign len_p1    = len_reg + PW'(1);
    assign cod_col   = cphase_reg ? !c_reg : c_reg;
    assign cod_hit   = ((state_reg == ST_COD_RD) && (cx_reg > p_reg) && (p_reg >= len_reg)) ||
                       ((state_reg == ST_COD_CHK) && (cod_bit != cod_col));
    assign found_pos = (state_reg == ST_COD_RD) ? len_p1 : cx_reg;

    assign a1_w    = {1'b0, a1_reg};
    assign b1_w    = {1'b0, b1_reg};
    assign is_vert = (a1_w + 3 >= b1_w) && (a1_w <= b1_w + 3);
    assign vdiff   = a1_reg + PW'(3) - b1_reg;
    assign v_vert  = vert_vlc(vdiff[2:0]);

    assign run1 = a1_reg - a0_reg - ((a0_reg == '0) ? PW'(1) : PW'(0));
    assign run2 = a2_reg - a1_reg;
    assign rk   = r_reg >> 6;
    assign k6   = (rk > RW'(40)) ? 6'd40 : rk[5:0];
    assign v_make = makeup_vlc(k6, rcol_reg);
    assign v_term = term_vlc(r_reg[5:0], rcol_reg);
    assign pad    = 3'd0 - pk_stat.count;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        ref_len_next = ref_len_reg;
        sel_next     = sel_reg;
        p_next       = p_reg;
        a0_next      = a0_reg;
        c_next       = c_reg;
        bvalid_next  = bvalid_reg;
        a1f_next     = a1f_reg;
        a2f_next     = a2f_reg;
        cphase_next  = cphase_reg;
        cx_next      = cx_reg;
        x_next       = x_reg;
        rph_next     = rph_reg;
        b1_next      = b1_reg;
        b2_next      = b2_reg;
        a1_next      = a1_reg;
        a2_next      = a2_reg;
        r_next       = r_reg;
        rcol_next    = rcol_reg;
        rsel_next    = rsel_reg;
        wr_en        = 1'b0;
        job          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_op) begin
                        state_next = ST_EOF_ISSUE;
                    end else begin
                        len_next   = l_cur;
                        p_next     = p_inc;
                        wr_en      = 1'b1;
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                if (a0_reg > len_reg) begin
                    if (p_reg >= len_reg) begin
                        // line done: it becomes the reference
                        sel_next     = !sel_reg;
                        ref_len_next = len_reg;
                        p_next       = '0;
                        a0_next      = '0;
                        c_next       = 1'b0;
                        bvalid_next  = 1'b0;
                        a1f_next     = 1'b0;
                        a2f_next     = 1'b0;
                        cphase_next  = 1'b0;
                        cx_next      = PW'(1);
                    end
                    state_next = ST_IDLE;
                end else if (!bvalid_reg) begin
                    x_next     = a0_reg;
                    rph_next   = RPH_Y;
                    state_next = ST_REF_RD;
                end else if (!a1f_reg) begin
                    state_next = ST_COD_RD;
                end else begin
                    state_next = ST_DECIDE;
                end
            end
            ST_REF_RD, ST_REF_CHK: begin
                if (ref_stop) begin
                    state_next = ST_REF_RD;
                    priority case (rph_reg)
                        RPH_Y: begin
                            rph_next = RPH_B1;
                        end
                        RPH_B1: begin
                            b1_next  = x_reg;
                            rph_next = RPH_B2;
                        end
                        default: begin
                            b2_next     = x_reg;
                            bvalid_next = 1'b1;
                            state_next  = ST_STEP;
                        end
                    endcase
                end else if (state_reg == ST_REF_RD) begin
                    state_next = ST_REF_CHK;
                end else begin
                    x_next     = x_reg + PW'(1);
                    state_next = ST_REF_RD;
                end
            end
            ST_COD_RD, ST_COD_CHK: begin
                if (cod_hit) begin
                    if (!cphase_reg) begin
                        a1_next     = found_pos;
                        a1f_next    = 1'b1;
                        cphase_next = 1'b1;
                        cx_next     = found_pos + PW'(1);
                        state_next  = ST_DECIDE;
                    end else begin
                        a2_next    = found_pos;
                        a2f_next   = 1'b1;
                        state_next = ST_HMODE;
                    end
                end else if (state_reg == ST_COD_RD) begin
                    if (cx_reg > p_reg) begin
                        // change not seen yet
                        state_next = cphase_reg ? ST_IDLE : ST_DECIDE;
                    end else begin
                        state_next = ST_COD_CHK;
                    end
                end else begin
                    cx_next    = cx_reg + PW'(1);
                    state_next = ST_COD_RD;
                end
            end
            ST_DECIDE: begin
                if (!a1f_reg && (b2_reg > p_reg)) begin
                    state_next = ST_IDLE;
                end else if (!a1f_reg || (b2_reg < a1_reg)) begin
                    if (!pk_stat.busy) begin
                        job.valid   = 1'b1;
                        job.code    = 32'h1;
                        job.len     = 5'd4;
                        a0_next     = b2_reg;
                        cx_next     = b2_reg + PW'(1);
                        bvalid_next = 1'b0;
                        a1f_next    = 1'b0;
                        a2f_next    = 1'b0;
                        cphase_next = 1'b0;
                        state_next  = ST_STEP;
                    end
                end else if (is_vert) begin
                    if (!pk_stat.busy) begin
                        job.valid   = 1'b1;
                        job.code    = {19'b0, v_vert.code};
                        job.len     = {1'b0, v_vert.len};
                        a0_next     = a1_reg;
                        c_next      = !c_reg;
                        cx_next     = a1_reg + PW'(1);
                        bvalid_next = 1'b0;
                        a1f_next    = 1'b0;
                        a2f_next    = 1'b0;
                        cphase_next = 1'b0;
                        state_next  = ST_STEP;
                    end
                end else if (a2f_reg) begin
                    state_next = ST_HMODE;
                end else begin
                    state_next = ST_COD_RD;
                end
            end
            ST_HMODE: begin
                if (!pk_stat.busy) begin
                    job.valid  = 1'b1;
                    job.code   = 32'h1;
                    job.len    = 5'd3;
                    r_next     = RW'(run1);
                    rcol_next  = c_reg;
                    rsel_next  = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!pk_stat.busy) begin
                    job.valid = 1'b1;
                    if (rk != '0) begin
                        job.code = {19'b0, v_make.code};
                        job.len  = {1'b0, v_make.len};
                        r_next   = r_reg - (RW'(k6) << 6);
                    end else begin
                        job.code = {19'b0, v_term.code};
                        job.len  = {1'b0, v_term.len};
                        if (!rsel_reg) begin
                            r_next    = RW'(run2);
                            rcol_next = !c_reg;
                            rsel_next = 1'b1;
                        end else begin
                            a0_next     = a2_reg;
                            cx_next     = a2_reg + PW'(1);
                            bvalid_next = 1'b0;
                            a1f_next    = 1'b0;
                            a2f_next    = 1'b0;
                            cphase_next = 1'b0;
                            state_next  = ST_STEP;
                        end
                    end
                end
            end
            ST_EOF_ISSUE: begin
                if (!pk_stat.busy) begin
                    // EOFB with zero padding folded in, so the last bit ends a byte
                    job.valid     = 1'b1;
                    job.code      = 32'h001001 << pad;
                    job.len       = 5'd24 + {2'b0, pad};
                    job.final_job = 1'b1;
                    state_next    = ST_EOF_WAIT;
                end
            end
            ST_EOF_WAIT: begin
                if (!pk_stat.busy) begin
                    sel_next     = 1'b0;
                    ref_len_next = '0;
                    p_next       = '0;
                    a0_next      = '0;
                    c_next       = 1'b0;
                    bvalid_next  = 1'b0;
                    a1f_next     = 1'b0;
                    a2f_next     = 1'b0;
                    cphase_next  = 1'b0;
                    cx_next      = PW'(1);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_reg <= G4FLE_WIDTH_RESET;
        end else if (cfg_wr_en) begin
            lw_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= PW'(G4FLE_WIDTH_RESET);
            ref_len_reg <= '0;
            sel_reg     <= 1'b0;
            p_reg       <= '0;
            a0_reg      <= '0;
            c_reg       <= 1'b0;
            bvalid_reg  <= 1'b0;
            a1f_reg     <= 1'b0;
            a2f_reg     <= 1'b0;
            cphase_reg  <= 1'b0;
            cx_reg      <= PW'(1);
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            ref_len_reg <= ref_len_next;
            sel_reg     <= sel_next;
            p_reg       <= p_next;
            a0_reg      <= a0_next;
            c_reg       <= c_next;
            bvalid_reg  <= bvalid_next;
            a1f_reg     <= a1f_next;
            a2f_reg     <= a2f_next;
            cphase_reg  <= cphase_next;
            cx_reg      <= cx_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        rph_reg  <= rph_next;
        b1_reg   <= b1_next;
        b2_reg   <= b2_next;
        a1_reg   <= a1_next;
        a2_reg   <= a2_next;
        r_reg    <= r_next;
        rcol_reg <= rcol_next;
        rsel_reg <= rsel_next;
    end

    `G4_ASSERT_NOW(a_job_when_idle, aclk, aresetn, job.valid, !pk_stat.busy)
    `G4_ASSERT_ALWAYS(a_a0_in_line, aclk, aresetn, a0_reg <= len_reg + 1'b1)
    `G4_ASSERT_NOW(a_b1_before_b2, aclk, aresetn, bvalid_reg, b1_reg <= b2_reg)

endmodule

[rtl/core/g4fle_ram.sv]
// Single-bit line store: one write port, one registered read port
module g4fle_ram
    import g4fle_pkg::*;
#(
    parameter int DEPTH = G4FLE_MAX_WIDTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic [AW-1:0] raddr,
    output logic          rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/g4fle_packer.sv]
// Bit-serial code packer: shifts code bits MSB first into bytes, output register
module g4fle_packer
    import g4fle_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pk_job_t    job,
    output pk_stat_t   stat,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last
);

    logic [G4FLE_CODE_W-1:0] code_reg, code_next;
    logic [G4FLE_LEN_W-1:0]  left_reg, left_next;
    logic                    fin_reg, fin_next;
    logic [7:0]              bits_reg, bits_next;
    logic [2:0]              cnt_reg, cnt_next;
    logic                    mv_reg, mv_next;
    logic [7:0]              mb_reg, mb_next;
    logic                    ml_reg, ml_next;
    logic [G4FLE_LEN_W-1:0]  bit_idx;
    logic                    cur_bit;
    logic [7:0]              shifted;
    logic                    out_free;

    assign bit_idx  = left_reg - 5'd1;
    assign cur_bit  = code_reg[bit_idx];
    assign shifted  = {bits_reg[6:0], cur_bit};
    assign out_free = !mv_reg || m_ready;

    always_comb begin
        code_next = code_reg;
        left_next = left_reg;
        fin_next  = fin_reg;
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        mv_next   = mv_reg;
        mb_next   = mb_reg;
        ml_next   = ml_reg;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        if (left_reg != '0) begin
            if (cnt_reg == 3'd7) begin
                // byte completes: wait for the output register to free up
                if (out_free) begin
                    mv_next   = 1'b1;
                    mb_next   = shifted;
                    ml_next   = fin_reg && (left_reg == 5'd1);
                    bits_next = '0;
                    cnt_next  = '0;
                    left_next = left_reg - 5'd1;
                end
            end else begin
                bits_next = shifted;
                cnt_next  = cnt_reg + 3'd1;
                left_next = left_reg - 5'd1;
            end
        end else if (job.valid) begin
            code_next = job.code;
            left_next = job.len;
            fin_next  = job.final_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
            bits_reg <= '0;
            cnt_reg  <= '0;
            mv_reg   <= 1'b0;
        end else begin
            left_reg <= left_next;
            bits_reg <= bits_next;
            cnt_reg  <= cnt_next;
            mv_reg   <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        fin_reg  <= fin_next;
        mb_reg   <= mb_next;
        ml_reg   <= ml_next;
    end

    assign stat.busy  = (left_reg != '0);
    assign stat.count = cnt_reg;
    assign m_valid    = mv_reg;
    assign m_out_byte = mb_reg;
    assign m_last     = ml_reg;

endmodule

[dv/g4_fax_line_encoder_unit_tb.sv]
// Testbench for the Group 4 line encoder: random pages checked against a T.6 code predictor
`timescale 1ns / 1ps
module g4_fax_line_encoder_unit_tb;
    import g4fle_pkg::*;

    localparam int MAXW = 4096;
    localparam logic OP_PEL = 1'b0;
    localparam logic OP_EOP = 1'b1;

    typedef struct packed {
        logic op;
        logic px;
    } pel_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } code_byte_t;

    // code tables: {code, length}
    localparam logic [15:0] WTERM [64] = '{
        'h358,'h076,'h074,'h084,'h0B4,'h0C4,'h0E4,'h0F4,
        'h135,'h145,'h075,'h085,'h086,'h036,'h346,'h356,
        'h2A6,'h2B6,'h277,'h0C7,'h087,'h177,'h037,'h047,
        'h287,'h2B7,'h137,'h247,'h187,'h028,'h038,'h1A8,
        'h1B8,'h128,'h138,'h148,'h158,'h168,'h178,'h288,
        'h298,'h2A8,'h2B8,'h2C8,'h2D8,'h048,'h058,'h0A8,
        'h0B8,'h528,'h538,'h548,'h558,'h248,'h258,'h588,
        'h598,'h5A8,'h5B8,'h4A8,'h4B8,'h328,'h338,'h348};
    localparam logic [15:0] BTERM [64] = '{
        'h37A,'h023,'h032,'h022,'h033,'h034,'h024,'h035,
        'h056,'h046,'h047,'h057,'h077,'h048,'h078,'h189,
        'h17A,'h18A,'h08A,'h67B,'h68B,'h6CB,'h37B,'h28B,
        'h17B,'h18B,'hCAC,'hCBC,'hCCC,'hCDC,'h68C,'h69C,
        'h6AC,'h6BC,'hD2C,'hD3C,'hD4C,'hD5C,'hD6C,'hD7C,
        'h6CC,'h6DC,'hDAC,'hDBC,'h54C,'h55C,'h56C,'h57C,
        'h64C,'h65C,'h52C,'h53C,'h24C,'h37C,'h38C,'h27C,
        'h28C,'h58C,'h59C,'h2BC,'h2CC,'h5AC,'h66C,'h67C};
    localparam logic [15:0] WMAKE [27] = '{
        'h1B5,'h125,'h176,'h377,'h368,'h378,'h648,'h658,
        'h688,'h678,'hCC9,'hCD9,'hD29,'hD39,'hD49,'hD59,
        'hD69,'hD79,'hD89,'hD99,'hDA9,'hDB9,'h989,'h999,
        'h9A9,'h186,'h9B9};
    localparam logic [15:0] BMAKE [27] = '{
        'h0FA,'hC8C,'hC9C,'h5BC,'h33C,'h34C,'h35C,'h6CD,
        'h6DD,'h4AD,'h4BD,'h4CD,'h4DD,'h72D,'h73D,'h74D,
        'h75D,'h76D,'h77D,'h52D,'h53D,'h54D,'h55D,'h5AD,
        'h5BD,'h64D,'h65D};
    localparam logic [15:0] XMAKE [13] = '{
        'h08B,'h0CB,'h0DB,'h12C,'h13C,'h14C,'h15C,'h16C,'h17C,'h1CC,'h1DC,'h1EC,'h1FC};
    localparam logic [15:0] VCODE [7] = '{'h027,'h026,'h023,'h011,'h033,'h036,'h037};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = 1'b0;
    logic        s_pixel = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last;
    logic        cfg_wr_en = 1'b0;
    logic [12:0] cfg_wr_data = 13'd0;

    g4_fax_line_encoder_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last      (m_last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    pel_item_t  pel_q[$];
    code_byte_t code_q[$];
    int         errs = 0;
    bit         s_quiet = 1'b0;
    bit         m_quiet = 1'b0;

    // ---------------- encoder state mirror ----------------
    bit         line_st [2][MAXW+1];
    int         width_reg = 1728;
    int         sel = 0, pos = 0, a0 = 0, color = 0, pbits = 0, pcnt = 0;
    int         llen = 1728, rlen = 0;

    task automatic put_code(input int code, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            pbits = ((pbits << 1) | ((code >> i) & 1)) & 'hFF;
            pcnt++;
            if (pcnt == 8) begin
                code_q.push_back('{pbits[7:0], 1'b0});
                pcnt = 0;
                pbits = 0;
            end
        end
    endtask

    task automatic put_entry(input logic [15:0] e);
        put_code(e[15:4], e[3:0]);
    endtask

    task automatic put_run(input int r, input bit black);
        int k;
        while (r >= 64) begin
            k = r / 64;
            if (k > 40) k = 40;
            if (k >= 28) put_entry(XMAKE[k-28]);
            else put_entry(black ? BMAKE[k-1] : WMAKE[k-1]);
            r -= k * 64;
        end
        put_entry(black ? BTERM[r] : WTERM[r]);
    endtask

    function automatic bit coding_px(input int x);
        if (x == 0 || x > MAXW) return 1'b0;
        return line_st[sel][x];
    endfunction

    // first x in [from, lim] where the reference line has color col, else lim+1
    function automatic int ref_seek(input int from, input int lim, input bit col);
        for (int x = from; x <= lim; x++) begin
            if (x > 0 && x > rlen) return col ? lim + 1 : x;
            if ((x == 0 ? 1'b0 : line_st[sel^1][x]) == col) return x;
        end
        return lim + 1;
    endfunction

    function automatic int coding_change(input int from, input bit col, input int p,
                                         input bit done);
        for (int x = from; x <= p; x++)
            if (coding_px(x) != col) return x;
        return done ? llen + 1 : 0;
    endfunction

    task automatic mode_search(input int p, input bit done);
        int y, b1, b2, a1, a2;
        bit c;
        while (a0 <= llen) begin
            c = color[0];
            y = ref_seek(a0, llen, c);
            b1 = ref_seek(y, llen, ~c);
            b2 = (b1 <= llen) ? ref_seek(b1, llen, c) : b1;
            a1 = coding_change(a0 + 1, c, p, done);
            if (a1 == 0 || b2 < a1) begin
                if (a1 == 0 && b2 > p) break;
                put_code('h1, 4);       // pass
                a0 = b2;
            end else if (a1 + 3 >= b1 && a1 <= b1 + 3) begin
                put_entry(VCODE[a1 + 3 - b1]);
                a0 = a1;
                color = color ^ 1;
            end else begin
                a2 = coding_change(a1 + 1, ~c, p, done);
                if (a2 == 0) break;
                put_code('h1, 3);       // horizontal
                put_run(a1 - a0 - (a0 == 0 ? 1 : 0), c);
                put_run(a2 - a1, ~c);
                a0 = a2;
            end
        end
    endtask

    task automatic encode_item(input pel_item_t it);
        if (it.op == OP_EOP) begin
            put_code('h001001, 24);
            if (pcnt != 0) put_code(0, 8 - pcnt);
            code_q[code_q.size()-1].last = 1'b1;
            sel = 0; pos = 0; a0 = 0; color = 0; pbits = 0; pcnt = 0; rlen = 0;
            return;
        end
        if (pos == 0) llen = (width_reg < 1) ? 1 : (width_reg > MAXW) ? MAXW : width_reg;
        pos++;
        if (pos > llen) pos = llen;
        line_st[sel][pos] = it.px;
        mode_search(pos, pos >= llen);
        if (pos >= llen) begin
            sel ^= 1;
            rlen = llen;
            pos = 0;
            a0 = 0;
            color = 0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------- input driver ----------------
    int s_gap = 0;
    always @(posedge aclk) begin
        pel_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) encode_item('{s_op, s_pixel});
            if (!(s_valid && !s_ready)) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (pel_q.size() > 0) begin
                    it = pel_q.pop_front();
                    s_op <= it.op;
                    s_pixel <= it.px;
                    s_valid <= 1'b1;
                    s_gap = s_quiet ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- output monitor ----------------
    int m_stall = 0;
    always @(posedge aclk) begin
        code_byte_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (code_q.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected byte %02h last %0b", m_out_byte, m_last);
                end else begin
                    e = code_q.pop_front();
                    if (e.data !== m_out_byte || e.last !== m_last) begin
                        errs++;
                        if (errs <= 10)
                            $display("byte mismatch: exp %02h/%0b got %02h/%0b",
                                     e.data, e.last, m_out_byte, m_last);
                    end
                end
            end
            if (m_stall > 0) begin
                m_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!m_quiet && $urandom_range(0, 3) == 0) m_stall = pick_gap();
            end
        end
    end

    // ---------------- stimulus ----------------
    bit stim_prev [MAXW+1];
    int rand_pels = 0;

    task automatic push_pel(input bit px);
        pel_q.push_back('{OP_PEL, px});
    endtask

    task automatic push_bits(input string s);
        for (int i = 0; i < s.len(); i++) push_pel(s[i] == "1");
    endtask

    // wait for all transfers to finish, then give the block time to settle
    task automatic drain();
        while (pel_q.size() != 0 || s_valid || code_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic page_width(input int w);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w[12:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        width_reg = w;
    endtask

    // mode 0: short runs, 1: previous line shifted, 2: long runs
    task automatic push_line(input int len, input int mode);
        bit c;
        int sh, j;
        bit px;
        c = $urandom_range(0, 1);
        sh = $urandom_range(0, 6) - 3;
        for (int i = 1; i <= len; i++) begin
            case (mode)
                0: begin
                    if ($urandom_range(0, 3) == 0) c = ~c;
                    px = c;
                end
                1: begin
                    j = i + sh;
                    px = (j >= 1 && j <= len) ? stim_prev[j] : 1'b0;
                    if ($urandom_range(0, 19) == 0) px = ~px;
                end
                default: begin
                    if ($urandom_range(0, 79) == 0) c = ~c;
                    px = c;
                end
            endcase
            stim_prev[i] = px;
            push_pel(px);
        end
        rand_pels += len;
    endtask

    initial begin
        int w, nl, mode, part;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // empty page, then width 0 clamped to one pel
        pel_q.push_back('{OP_EOP, 1'b0});
        page_width(0);
        push_bits("10");
        pel_q.push_back('{OP_EOP, 1'b1});

        // vertical, pass and horizontal on short lines; end of page mid-line
        page_width(8);
        push_bits("01100011");
        push_bits("01100011");
        push_bits("00000111");
        push_bits("11111110");
        push_bits("101");
        pel_q.push_back('{OP_EOP, 1'b0});

        // width above the maximum; runs long enough for makeup codes, page ends mid-line
        page_width(8191);
        for (int i = 0; i < 100; i++) push_pel(1'b0);
        for (int i = 0; i < 40; i++) push_pel(1'b1);
        push_pel(1'b0);
        pel_q.push_back('{OP_EOP, 1'b0});

        page_width(4096);
        for (int i = 0; i < 20; i++) push_pel(1'b1);
        pel_q.push_back('{OP_EOP, 1'b0});

        // random pages
        while (rand_pels < 150) begin
            mode = $urandom_range(0, 9);
            w = (mode < 7) ? $urandom_range(1, 40) :
                (mode < 9) ? $urandom_range(64, 120) : $urandom_range(1, 8);
            page_width(w);
            s_quiet = ($urandom_range(0, 3) == 0);
            m_quiet = ($urandom_range(0, 3) == 0);
            nl = (w >= 64) ? 1 : $urandom_range(1, 4);
            for (int l = 0; l < nl; l++)
                push_line(w, (w >= 64) ? 2 : (l == 0 ? 0 : $urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0) begin
                part = $urandom_range(1, w);
                push_line(part, 0);
            end
            pel_q.push_back('{OP_EOP, 1'($urandom_range(0, 1))});
        end

        drain();
        if (errs == 0) begin
            $display("g4_fax_line_encoder_unit verification clean");
        end else begin
            $display("g4_fax_line_encoder_unit verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("g4_fax_line_encoder_unit verification failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/g4fle_pkg.sv
rtl/core/g4fle_ram.sv
rtl/core/g4fle_packer.sv
rtl/core/g4_fax_line_encoder_unit.sv
dv/g4_fax_line_encoder_unit_tb.sv
